// ===== hw/rtl/conv2d_valid_normalized_top_macros.svh =====
// Assertion macros for the 2-D valid-mode convolution block
`ifndef CONV2D_VALID_NORMALIZED_TOP_MACROS_SVH
`define CONV2D_VALID_NORMALIZED_TOP_MACROS_SVH

// Check a property while out of reset
`define C2DVN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included
`define C2DVN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/c2dvn_pkg.sv =====
// Shared types and constants for the 2-D valid-mode convolution block
`timescale 1ns / 1ps
package c2dvn_pkg;

  localparam int HEIGHT_CAP = 1024;
  localparam int SIZE_REG_W = 3;
  localparam int DIM_REG_W  = 11;
  localparam int COEF_STR_W = 200;

  localparam logic [2:0] REG_KSIZE  = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_COEF_A = 3'd3;
  localparam logic [2:0] REG_COEF_B = 3'd4;
  localparam logic [2:0] REG_COEF_C = 3'd5;
  localparam logic [2:0] REG_COEF_D = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/conv2d_valid_normalized_top.sv =====
// Top level: config registers, line store, window cell chain, divider, output register
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//  input    | in_valid/in_ready      | pixel, frame_start
//  output   | out_valid/out_ready    | filtered, zero_divisor, frame_last
//
// A pixel with no result passes the store read/write, then the window shift.
// A pixel with a result also passes the cell chain, which carries row sums down, and
// then the divider, which is skipped when the kernel sum is zero.
// Reset is synchronous; the line store needs no clearing pass.
// A result waiting on out_ready does not block the next pixel until the next
// result is ready to be loaded.
`timescale 1ns / 1ps
module conv2d_valid_normalized_top #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int COEFF_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic                  frame_start,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [PIXEL_BITS+COEFF_BITS+$clog2(MAX_KERNEL*MAX_KERNEL)-1:0] filtered,
  output logic zero_divisor,
  output logic frame_last
);
  import c2dvn_pkg::*;

  localparam int MK    = MAX_KERNEL;
  localparam int PB    = PIXEL_BITS;
  localparam int CB    = COEFF_BITS;
  localparam int NC    = MK * MK;
  localparam int ACC_W = PB + CB + $clog2(NC);
  localparam int KS_W  = CB + $clog2(NC);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(HEIGHT_CAP);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(HEIGHT_CAP + 1);
  localparam int KW    = $clog2(MK + 1);
  localparam int BW    = (MK > 1) ? $clog2(MK) : 1;
  localparam int SW    = (NC * CB > COEF_STR_W) ? NC * CB : COEF_STR_W;
  localparam int MCW   = $clog2(MK + 2);

  // configuration registers
  logic [SIZE_REG_W-1:0] ksize_reg;
  logic [DIM_REG_W-1:0]  width_reg;
  logic [DIM_REG_W-1:0]  height_reg;
  logic [63:0]           coef_a, coef_b, coef_c;
  logic [7:0]            coef_d;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ksize_reg  <= SIZE_REG_W'(3);
      width_reg  <= DIM_REG_W'(640);
      height_reg <= DIM_REG_W'(480);
      coef_a     <= '0;
      coef_b     <= '0;
      coef_c     <= '0;
      coef_d     <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_KSIZE:  ksize_reg  <= pwdata[SIZE_REG_W-1:0];
        REG_WIDTH:  width_reg  <= pwdata[DIM_REG_W-1:0];
        REG_HEIGHT: height_reg <= pwdata[DIM_REG_W-1:0];
        REG_COEF_A: coef_a     <= pwdata;
        REG_COEF_B: coef_b     <= pwdata;
        REG_COEF_C: coef_c     <= pwdata;
        REG_COEF_D: coef_d     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_KSIZE:  prdata = 64'(ksize_reg);
      REG_WIDTH:  prdata = 64'(width_reg);
      REG_HEIGHT: prdata = 64'(height_reg);
      REG_COEF_A: prdata = coef_a;
      REG_COEF_B: prdata = coef_b;
      REG_COEF_C: prdata = coef_c;
      REG_COEF_D: prdata = 64'(coef_d);
      default:    prdata = '0;
    endcase
  end

  // frame state
  state_t        state, state_next;
  logic [AW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [BW-1:0] row_bank;
  logic [KW-1:0] lat_k;
  logic [WW-1:0] lat_w;
  logic [HW-1:0] lat_h;

  logic          accept;
  logic          latch;
  logic [AW-1:0] c_eff;
  logic [RW-1:0] r_eff;
  logic [BW-1:0] rb_eff;
  logic [KW-1:0] k_new, k_use;
  logic [WW-1:0] w_new, w_use;
  logic [HW-1:0] h_new, h_use;
  logic          produce, last_pos;
  logic [AW-1:0] col_cnt_next;
  logic [RW-1:0] row_cnt_next;
  logic [BW-1:0] row_bank_next;

  assign accept = in_valid & in_ready;
  assign c_eff  = frame_start ? '0 : col_cnt;
  assign r_eff  = frame_start ? '0 : row_cnt;
  assign rb_eff = frame_start ? '0 : row_bank;
  assign latch  = (c_eff == '0) && (r_eff == '0);

  always_comb begin
    if (ksize_reg == '0) k_new = KW'(1);
    else if (32'(ksize_reg) > MK) k_new = KW'(MK);
    else k_new = KW'(ksize_reg);
    if (width_reg == '0) w_new = WW'(1);
    else if (32'(width_reg) > MAX_WIDTH) w_new = WW'(MAX_WIDTH);
    else w_new = WW'(width_reg);
    if (height_reg == '0) h_new = HW'(1);
    else if (32'(height_reg) > HEIGHT_CAP) h_new = HW'(HEIGHT_CAP);
    else h_new = HW'(height_reg);
  end

  assign k_use = latch ? k_new : lat_k;
  assign w_use = latch ? w_new : lat_w;
  assign h_use = latch ? h_new : lat_h;

  always_comb begin
    produce  = (32'(k_use) <= 32'(w_use)) && (32'(k_use) <= 32'(h_use)) &&
               (32'(r_eff) + 1 >= 32'(k_use)) && (32'(c_eff) + 1 >= 32'(k_use));
    last_pos = (32'(r_eff) == 32'(h_use) - 1) && (32'(c_eff) == 32'(w_use) - 1);
    col_cnt_next  = c_eff + 1'b1;
    row_cnt_next  = r_eff;
    row_bank_next = rb_eff;
    if (32'(c_eff) + 1 >= 32'(w_use)) begin
      col_cnt_next = '0;
      if (32'(r_eff) + 1 >= 32'(h_use)) begin
        row_cnt_next  = '0;
        row_bank_next = '0;
      end else begin
        row_cnt_next  = r_eff + 1'b1;
        row_bank_next = (32'(rb_eff) == MK - 1) ? '0 : rb_eff + 1'b1;
      end
    end
  end

  // coefficients aligned to the bottom-right corner of the cell grid
  logic [SW-1:0]       coef_str;
  logic [MK*CB-1:0]    coef_rows [MK];

  assign coef_str = SW'({coef_d, coef_c, coef_b, coef_a});

  always_comb begin
    int off;
    int idx;
    off = MK - 32'(k_new);
    for (int i = 0; i < MK; i++) begin
      for (int j = 0; j < MK; j++) begin
        idx = (i - off) * 32'(k_new) + (j - off);
        if (i >= off && j >= off) coef_rows[i][j*CB +: CB] = coef_str[idx*CB +: CB];
        else coef_rows[i][j*CB +: CB] = '0;
      end
    end
  end

  // registered pixel context
  logic [PB-1:0] px_q;
  logic [BW-1:0] rb_q;
  logic          produce_q, last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      row_bank <= '0;
      lat_k    <= KW'(3);
      lat_w    <= WW'(640);
      lat_h    <= HW'(480);
    end else if (accept) begin
      col_cnt  <= col_cnt_next;
      row_cnt  <= row_cnt_next;
      row_bank <= row_bank_next;
      if (latch) begin
        lat_k <= k_new;
        lat_w <= w_new;
        lat_h <= h_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_q      <= pixel;
      rb_q      <= rb_eff;
      produce_q <= produce;
      last_q    <= last_pos;
    end
  end

  // line store, one bank per row modulo the kernel limit
  logic [PB-1:0] line_mem [MK][MAX_WIDTH];
  logic [PB-1:0] rd_data [MK];

  for (genvar b = 0; b < MK; b++) begin : g_bank
    always_ff @(posedge clk) begin
      if (accept) begin
        if (32'(rb_eff) == b) line_mem[b][c_eff] <= pixel;
        rd_data[b] <= line_mem[b][c_eff];
      end
    end
  end

  // cell chain
  cell_ctrl_t              cell_ctrl;
  logic [PB-1:0]           cell_pix [MK];
  logic signed [ACC_W-1:0] acc_link [MK+1];
  logic signed [KS_W-1:0]  ks_link [MK+1];

  assign acc_link[0] = '0;
  assign ks_link[0]  = '0;

  always_comb begin
    int s;
    for (int i = 0; i < MK - 1; i++) begin
      s = 32'(rb_q) + i + 1;
      if (s >= MK) s = s - MK;
      cell_pix[i] = rd_data[BW'(s)];
    end
    // bottom row comes straight from the pixel just taken
    cell_pix[MK-1] = px_q;
  end

  for (genvar i = 0; i < MK; i++) begin : g_cell
    c2dvn_cell #(
      .MK(MK), .PB(PB), .CB(CB), .ACC_W(ACC_W), .KS_W(KS_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .pix_in  (cell_pix[i]),
      .coef_row(coef_rows[i]),
      .acc_in  (acc_link[i]),
      .ks_in   (ks_link[i]),
      .acc_out (acc_link[i+1]),
      .ks_out  (ks_link[i+1])
    );
  end

  // sequencing
  logic [MCW-1:0]          mac_cnt;
  logic                    chain_done;
  logic                    div_start, div_done;
  logic signed [ACC_W-1:0] div_q;
  logic signed [ACC_W-1:0] res;
  logic                    res_zero;
  logic                    out_load;

  assign chain_done = (32'(mac_cnt) == MK + 1);

  c2dvn_div #(.DW(ACC_W), .VW(KS_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc_link[MK]),
    .divisor (ks_link[MK]),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_SHIFT;
      ST_SHIFT: state_next = produce_q ? ST_MAC : ST_IDLE;
      ST_MAC: begin
        if (chain_done) state_next = (ks_link[MK] == '0) ? ST_OUT : ST_DIV;
      end
      ST_DIV:   if (div_done) state_next = ST_OUT;
      ST_OUT:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == ST_IDLE);
    cell_ctrl.shift = (state == ST_SHIFT);
    cell_ctrl.load  = accept && latch;
    div_start       = (state == ST_MAC) && chain_done && (ks_link[MK] != '0);
    out_load        = (state == ST_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_SHIFT) mac_cnt <= '0;
    else if (state == ST_MAC && !chain_done) mac_cnt <= mac_cnt + 1'b1;
    if (state == ST_MAC && chain_done) begin
      res      <= '0;
      res_zero <= (ks_link[MK] == '0);
    end else if (div_done) begin
      res <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered     <= res;
      zero_divisor <= res_zero;
      frame_last   <= last_q;
    end
  end

endmodule

// ===== hw/rtl/c2dvn_cell.sv =====
// One window row: column shift line, row dot product and accumulate link
`timescale 1ns / 1ps
module c2dvn_cell #(
  parameter int MK    = 5,
  parameter int PB    = 8,
  parameter int CB    = 8,
  parameter int ACC_W = 21,
  parameter int KS_W  = 13
) (
  input  logic                    clk,
  input  c2dvn_pkg::cell_ctrl_t   ctrl,
  input  logic [PB-1:0]           pix_in,
  input  logic [MK*CB-1:0]        coef_row,
  input  logic signed [ACC_W-1:0] acc_in,
  input  logic signed [KS_W-1:0]  ks_in,
  output logic signed [ACC_W-1:0] acc_out,
  output logic signed [KS_W-1:0]  ks_out
);
  import c2dvn_pkg::*;

  logic [PB-1:0]           col [MK];
  logic signed [CB-1:0]    coef [MK];
  logic signed [ACC_W-1:0] rowdot;
  logic signed [KS_W-1:0]  rowks;
  logic signed [ACC_W-1:0] rowdot_next;
  logic signed [KS_W-1:0]  rowks_next;

  always_comb begin
    logic signed [PB+CB:0] prod;
    rowdot_next = '0;
    rowks_next  = '0;
    for (int j = 0; j < MK; j++) begin
      // drop taps outside the kernel so stale or unwritten pixels never reach the sum
      if (coef[j] == '0) prod = '0;
      else prod = $signed({1'b0, col[j]}) * coef[j];
      rowdot_next = rowdot_next + ACC_W'(prod);
      rowks_next  = rowks_next + KS_W'(coef[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int j = 0; j < MK - 1; j++) col[j] <= col[j+1];
      col[MK-1] <= pix_in;
    end
    if (ctrl.load) begin
      for (int j = 0; j < MK; j++) coef[j] <= coef_row[j*CB +: CB];
    end
    rowdot  <= rowdot_next;
    rowks   <= rowks_next;
    // pass the running sums down the chain
    acc_out <= acc_in + rowdot;
    ks_out  <= ks_in + rowks;
  end

endmodule

// ===== hw/rtl/c2dvn_div.sv =====
// Restoring divider, one quotient bit per cycle, truncates toward zero
`timescale 1ns / 1ps
module c2dvn_div #(
  parameter int DW = 21,
  parameter int VW = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic signed [VW-1:0] divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);
  import c2dvn_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [DW-1:0] dvd;
  logic [VW-1:0] dvs;
  logic [VW-1:0] rem;
  logic [VW:0]   rem_sh;
  logic          ge;

  assign rem_sh   = {rem, dvd[DW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = neg ? -$signed(dvd) : $signed(dvd);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1] ^ divisor[VW-1];
      dvd <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      dvs <= divisor[VW-1] ? VW'(-divisor) : VW'(divisor);
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? VW'(rem_sh - {1'b0, dvs}) : VW'(rem_sh);
      dvd <= {dvd[DW-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/c2dvn_checker.sv =====
// Port-level checks for the convolution top level, bound to it
`timescale 1ns / 1ps
`include "conv2d_valid_normalized_top_macros.svh"
module c2dvn_checker #(
  parameter int FW = 21
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 pready,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [FW-1:0] filtered,
  input logic                 zero_divisor,
  input logic                 frame_last
);
  import c2dvn_pkg::*;

  // a stalled result keeps its payload
  `C2DVN_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(zero_divisor) && $stable(frame_last), "stalled result changed")
  // a zero kernel sum always yields zero
  `C2DVN_ASSERT(a_zero_div, out_valid && zero_divisor |-> filtered == '0, "zero divisor with nonzero result")
  // one pixel in flight at a time
  `C2DVN_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while busy")
  // reset empties the output register
  `C2DVN_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid && pready, "output valid after reset")

endmodule

bind conv2d_valid_normalized_top c2dvn_checker u_c2dvn_checker (.*);
